// ===== rtl/core/nps_pkg.sv =====
`timescale 1ns / 1ps

package nps_pkg;

    localparam int IDX_W        = 48;
    localparam int SIZE_REGS    = 4;
    localparam int AX_W         = 2;
    localparam int CNT_W        = 3;
    localparam int AXIS_W       = 8;
    localparam int DEF_MAX_DIMS = 4;
    localparam int DEF_DIM_BITS = 12;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;

    typedef logic [2:0] t_reg_idx;
    typedef logic [1:0] t_status;

    localparam t_reg_idx REG_DIM_CNT = 3'd0;
    localparam t_reg_idx REG_SIZE0   = 3'd1;
    localparam t_reg_idx REG_SIZE1   = 3'd2;
    localparam t_reg_idx REG_SIZE2   = 3'd3;
    localparam t_reg_idx REG_SIZE3   = 3'd4;
    localparam t_reg_idx REG_AXIS    = 3'd5;

    localparam t_status ST_OK          = 2'd0;
    localparam t_status ST_AXIS_RANGE  = 2'd1;
    localparam t_status ST_AXIS_REPEAT = 2'd2;
    localparam t_status ST_BEYOND      = 2'd3;

    localparam logic [CNT_W-1:0]  RST_DIM_CNT = 3'd1;
    localparam logic [AXIS_W-1:0] RST_AXIS    = 8'd228;

endpackage

// ===== rtl/core/nps_div_cell.sv =====
`timescale 1ns / 1ps

module nps_div_cell #(
    parameter int MAX_DIMS  = nps_pkg::DEF_MAX_DIMS,
    parameter int DIM_BITS  = nps_pkg::DEF_DIM_BITS,
    parameter int DIM       = 0,
    parameter bit LAST_STEP = 1'b0
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_v,
    input  logic [nps_pkg::IDX_W-1:0]                     i_quo,
    input  logic [DIM_BITS-1:0]                           i_rem,
    input  logic [MAX_DIMS-1:0][DIM_BITS-1:0]             i_crd,
    input  logic [DIM_BITS-1:0]                           i_div,
    output logic                                          o_v,
    output logic [nps_pkg::IDX_W-1:0]                     o_quo,
    output logic [DIM_BITS-1:0]                           o_rem,
    output logic [MAX_DIMS-1:0][DIM_BITS-1:0]             o_crd
);
    import nps_pkg::*;

    logic                             r_v;
    logic [IDX_W-1:0]                 r_quo, n_quo;
    logic [DIM_BITS-1:0]              r_rem, n_rem;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] r_crd, n_crd;
    logic [DIM_BITS:0]                w_sh, w_dif;
    logic                             w_ge;

    // one restoring division step
    always_comb begin
        w_sh  = {i_rem, i_quo[IDX_W-1]};
        w_ge  = (w_sh >= {1'b0, i_div});
        w_dif = w_sh - {1'b0, i_div};
        n_quo = {i_quo[IDX_W-2:0], w_ge};
        n_crd = i_crd;
        if (w_ge) begin
            n_rem = w_dif[DIM_BITS-1:0];
        end else begin
            n_rem = w_sh[DIM_BITS-1:0];
        end
        if (LAST_STEP) begin
            n_crd[DIM] = n_rem;
            n_rem      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_crd <= n_crd;
        end
    end

    assign o_v   = r_v;
    assign o_quo = r_quo;
    assign o_rem = r_rem;
    assign o_crd = r_crd;

endmodule

// ===== rtl/core/nps_mac_cell.sv =====
`timescale 1ns / 1ps

module nps_mac_cell #(
    parameter int MAX_DIMS = nps_pkg::DEF_MAX_DIMS,
    parameter int DIM_BITS = nps_pkg::DEF_DIM_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_v,
    input  logic                              i_flag,
    input  logic [nps_pkg::IDX_W-1:0]         i_acc,
    input  logic [MAX_DIMS-1:0][DIM_BITS-1:0] i_crd,
    input  logic [MAX_DIMS-1:0]               i_pick,
    input  logic [DIM_BITS-1:0]               i_ext,
    output logic                              o_v,
    output logic                              o_flag,
    output logic [nps_pkg::IDX_W-1:0]         o_acc,
    output logic [MAX_DIMS-1:0][DIM_BITS-1:0] o_crd
);
    import nps_pkg::*;

    logic                              r_v, r_flag;
    logic [IDX_W-1:0]                  r_acc, n_acc;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] r_crd;
    logic [DIM_BITS-1:0]               w_c;
    logic [IDX_W+DIM_BITS-1:0]         w_prod;

    // horner step: acc * extent + coordinate of this input axis
    always_comb begin
        w_c = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (i_pick[d]) begin
                w_c = w_c | i_crd[d];
            end
        end
        w_prod = i_acc * i_ext;
        n_acc  = w_prod[IDX_W-1:0] + IDX_W'(w_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc  <= n_acc;
            r_flag <= i_flag;
            r_crd  <= i_crd;
        end
    end

    assign o_v    = r_v;
    assign o_flag = r_flag;
    assign o_acc  = r_acc;
    assign o_crd  = r_crd;

endmodule

// ===== rtl/core/nd_permute_source_address.sv =====
`timescale 1ns / 1ps

// Permute source-address generator. Takes one output flat index per clock
// while o_in_ready is high and returns the source flat index with a status
// code. The output index is taken apart into coordinates by a chain of cells
// that each perform one restoring division step (48 per dimension), then a
// row of multiply-add cells rebuilds the source index, then the output
// register. A two-entry output stage lets new transfers enter while a result
// waits. Configuration is read live, so the user must see that it is written
// only when no transfer is in flight; the block itself does not enforce this.
module nd_permute_source_address #(
    parameter int MAX_DIMS = nps_pkg::DEF_MAX_DIMS,
    parameter int DIM_BITS = nps_pkg::DEF_DIM_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nps_pkg::ADDR_W-1:0]    paddr,
    input  logic [nps_pkg::DATA_W-1:0]    pwdata,
    output logic [nps_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [nps_pkg::IDX_W-1:0]     i_output_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [nps_pkg::IDX_W-1:0]     o_source_index,
    output nps_pkg::t_status              o_status
);
    import nps_pkg::*;

    localparam int NSTEP = MAX_DIMS * IDX_W;
    localparam int NCW   = $clog2(MAX_DIMS + 1);

    logic [CNT_W-1:0]                   r_dim_cnt;
    logic [SIZE_REGS-1:0][DIM_BITS-1:0] r_size;
    logic [AXIS_W-1:0]                  r_axis;

    logic [NCW-1:0]                     w_cnt;
    logic [MAX_DIMS-1:0][AX_W-1:0]      w_ax;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0]  w_div;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0]  w_ext;
    logic [MAX_DIMS-1:0][MAX_DIMS-1:0]  w_pick;
    logic [SIZE_REGS-1:0]               w_used;
    t_status                            w_axis_st;
    logic                               w_zero;
    logic                               w_en;
    t_reg_idx                           w_idx;

    logic [NSTEP:0]                              s_v;
    logic [NSTEP:0][IDX_W-1:0]                   s_q;
    logic [NSTEP:0][DIM_BITS-1:0]                s_r;
    logic [NSTEP:0][MAX_DIMS-1:0][DIM_BITS-1:0]  s_c;

    logic [MAX_DIMS:0]                              m_v;
    logic [MAX_DIMS:0]                              m_f;
    logic [MAX_DIMS:0][IDX_W-1:0]                   m_acc;
    logic [MAX_DIMS:0][MAX_DIMS-1:0][DIM_BITS-1:0]  m_c;

    logic             r_out_v, r_skid_v;
    logic [IDX_W-1:0] r_out_src, r_skid_src, w_src;
    t_status          r_out_st, r_skid_st, w_st;
    logic             w_take;

    // configuration port
    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_cnt <= RST_DIM_CNT;
            for (int k = 0; k < SIZE_REGS; k++) begin
                r_size[k] <= DIM_BITS'(1);
            end
            r_axis <= RST_AXIS;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_DIM_CNT: r_dim_cnt <= pwdata[CNT_W-1:0];
                REG_SIZE0:   r_size[0] <= pwdata[DIM_BITS-1:0];
                REG_SIZE1:   r_size[1] <= pwdata[DIM_BITS-1:0];
                REG_SIZE2:   r_size[2] <= pwdata[DIM_BITS-1:0];
                REG_SIZE3:   r_size[3] <= pwdata[DIM_BITS-1:0];
                REG_AXIS:    r_axis    <= pwdata[AXIS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DIM_CNT: prdata = DATA_W'(r_dim_cnt);
            REG_SIZE0:   prdata = DATA_W'(r_size[0]);
            REG_SIZE1:   prdata = DATA_W'(r_size[1]);
            REG_SIZE2:   prdata = DATA_W'(r_size[2]);
            REG_SIZE3:   prdata = DATA_W'(r_size[3]);
            REG_AXIS:    prdata = DATA_W'(r_axis);
            default:     prdata = '0;
        endcase
    end

    // derived shape
    always_comb begin
        if (r_dim_cnt == '0) begin
            w_cnt = NCW'(1);
        end else if (32'(r_dim_cnt) > MAX_DIMS) begin
            w_cnt = NCW'(MAX_DIMS);
        end else begin
            w_cnt = NCW'(r_dim_cnt);
        end

        for (int d = 0; d < MAX_DIMS; d++) begin
            w_ax[d] = AX_W'(r_axis >> (AX_W * d));
            if (d < 32'(w_cnt)) begin
                w_div[d] = r_size[w_ax[d]];
            end else begin
                w_div[d] = DIM_BITS'(1);
            end
        end

        w_zero = 1'b0;
        for (int k = 0; k < MAX_DIMS; k++) begin
            w_ext[k] = DIM_BITS'(1);
            if (k < 32'(w_cnt) && k < SIZE_REGS) begin
                w_ext[k] = r_size[AX_W'(k)];
                if (r_size[AX_W'(k)] == '0) begin
                    w_zero = 1'b1;
                end
            end
            for (int d = 0; d < MAX_DIMS; d++) begin
                w_pick[k][d] = (d < 32'(w_cnt)) && (32'(w_ax[d]) == k);
            end
        end

        w_used    = '0;
        w_axis_st = ST_OK;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (d < 32'(w_cnt) && w_axis_st == ST_OK) begin
                if (32'(w_ax[d]) >= 32'(w_cnt)) begin
                    w_axis_st = ST_AXIS_RANGE;
                end else if (w_used[w_ax[d]]) begin
                    w_axis_st = ST_AXIS_REPEAT;
                end else begin
                    w_used[w_ax[d]] = 1'b1;
                end
            end
        end
    end

    // division chain, innermost output dimension first
    assign w_en       = !r_skid_v;
    assign o_in_ready = w_en;

    assign s_v[0] = i_in_valid;
    assign s_q[0] = i_output_index;
    assign s_r[0] = '0;
    assign s_c[0] = '0;

    for (genvar s = 0; s < NSTEP; s++) begin : g_div
        nps_div_cell #(
            .MAX_DIMS  (MAX_DIMS),
            .DIM_BITS  (DIM_BITS),
            .DIM       (MAX_DIMS - 1 - s / IDX_W),
            .LAST_STEP ((s % IDX_W) == IDX_W - 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_v     (s_v[s]),
            .i_quo   (s_q[s]),
            .i_rem   (s_r[s]),
            .i_crd   (s_c[s]),
            .i_div   (w_div[MAX_DIMS - 1 - s / IDX_W]),
            .o_v     (s_v[s+1]),
            .o_quo   (s_q[s+1]),
            .o_rem   (s_r[s+1]),
            .o_crd   (s_c[s+1])
        );
    end

    // source index rebuild, input axis 0 first
    assign m_v[0]   = s_v[NSTEP];
    assign m_f[0]   = |s_q[NSTEP];
    assign m_acc[0] = '0;
    assign m_c[0]   = s_c[NSTEP];

    for (genvar k = 0; k < MAX_DIMS; k++) begin : g_mac
        nps_mac_cell #(
            .MAX_DIMS (MAX_DIMS),
            .DIM_BITS (DIM_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_v     (m_v[k]),
            .i_flag  (m_f[k]),
            .i_acc   (m_acc[k]),
            .i_crd   (m_c[k]),
            .i_pick  (w_pick[k]),
            .i_ext   (w_ext[k]),
            .o_v     (m_v[k+1]),
            .o_flag  (m_f[k+1]),
            .o_acc   (m_acc[k+1]),
            .o_crd   (m_c[k+1])
        );
    end

    // status and output stage with skid entry
    always_comb begin
        if (w_axis_st != ST_OK) begin
            w_st = w_axis_st;
        end else if (w_zero || m_f[MAX_DIMS]) begin
            w_st = ST_BEYOND;
        end else begin
            w_st = ST_OK;
        end
        w_src = (w_st == ST_OK) ? m_acc[MAX_DIMS] : '0;
    end

    assign w_take = r_out_v && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_out_src <= r_skid_src;
                r_out_st  <= r_skid_st;
                r_skid_v  <= 1'b0;
            end
        end else if (m_v[MAX_DIMS]) begin
            if (!r_out_v || w_take) begin
                r_out_src <= w_src;
                r_out_st  <= w_st;
                r_out_v   <= 1'b1;
            end else begin
                r_skid_src <= w_src;
                r_skid_st  <= w_st;
                r_skid_v   <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_source_index = r_out_src;
    assign o_status       = r_out_st;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without output entry");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_st != ST_OK) |-> (r_out_src == '0))
        else $error("nonzero source index on error");

    a_stall_keeps_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_out_ready) |=> r_skid_v)
        else $error("skid entry lost while output stalled");
`endif

endmodule
